FILE: rtl/caf_pkg.sv
package caf_pkg;

   localparam int NUM_AXES_DEFAULT = 6;
   localparam int AXIS_W           = 3;
   localparam int DATA_W           = 32;
   localparam int COEF_W           = 16;
   localparam int DT_W             = 24;
   localparam int CSR_IDX_W        = 3;
   localparam int CSR_DATA_W       = 48;
   localparam int MASK_W           = 6;
   localparam logic [DT_W-1:0] DT_RESET = 24'd33554;

   localparam int SQRT_RAD_W  = 52;
   localparam int SQRT_ROOT_W = 26;
   localparam int SQRT_REM_W  = 30;
   localparam int DIV_W       = 64;
   localparam int DIVISOR_W   = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STIFF_LO = 3'd0,
      CSR_STIFF_HI = 3'd1,
      CSR_MASS_LO  = 3'd2,
      CSR_MASS_HI  = 3'd3,
      CSR_RATIO_LO = 3'd4,
      CSR_RATIO_HI = 3'd5,
      CSR_MODE     = 3'd6,
      CSR_DT       = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      ORDER_SPRING = 2'd0,
      ORDER_DAMPER = 2'd1,
      ORDER_MASS   = 2'd2,
      ORDER_BAD    = 2'd3
   } order_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_ORDER = 2'd1,
      STATUS_ZERO_DIV  = 2'd2,
      STATUS_SAT       = 2'd3
   } status_type;

   typedef struct packed {
      logic [AXIS_W-1:0]        axis;
      logic signed [DATA_W-1:0] position_ref;
      logic signed [DATA_W-1:0] velocity_ref;
      logic signed [DATA_W-1:0] accel_ref;
      logic signed [DATA_W-1:0] wrench_error;
   } req_payload_type;

   typedef struct packed {
      logic [AXIS_W-1:0]        axis_out;
      logic signed [DATA_W-1:0] position_cmd;
      logic signed [DATA_W-1:0] velocity_cmd;
      logic signed [DATA_W-1:0] accel_cmd;
      logic [1:0]               status;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] position;
      logic signed [DATA_W-1:0] velocity;
   } axis_state_type;

   function automatic logic [DATA_W:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return {1'b1, 32'h7fff_ffff};
      end else if (v < -64'sd2147483648) begin
         return {1'b1, 32'h8000_0000};
      end else begin
         return {1'b0, v[DATA_W-1:0]};
      end
   endfunction

endpackage

FILE: rtl/caf_stream_if.sv
interface caf_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/caf_state_mem.sv
module caf_state_mem #(
   parameter int Depth = caf_pkg::NUM_AXES_DEFAULT,
   parameter int AddrW = 3
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    rd_en,
   input  logic [AddrW-1:0]        rd_addr,
   output caf_pkg::axis_state_type rd_data,
   input  logic                    wr_en,
   input  logic [AddrW-1:0]        wr_addr,
   input  caf_pkg::axis_state_type wr_data
);
   import caf_pkg::*;

   axis_state_type mem [Depth];
   logic [Depth-1:0] valid_ff;
   axis_state_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/caf_isqrt.sv
module caf_isqrt (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [caf_pkg::SQRT_RAD_W-1:0]   radicand,
   output logic                             done,
   output logic [caf_pkg::SQRT_ROOT_W-1:0]  root
);
   import caf_pkg::*;

   localparam int CntW = $clog2(SQRT_ROOT_W);

   logic [SQRT_RAD_W-1:0]  rad_ff;
   logic [SQRT_REM_W-1:0]  rem_ff;
   logic [SQRT_ROOT_W-1:0] root_ff;
   logic [CntW-1:0]        cnt_ff;
   logic                   busy_ff;
   logic                   done_ff;
   logic [SQRT_REM_W-1:0]  rem_sh;
   logic [SQRT_REM_W-1:0]  trial;

   assign rem_sh = {rem_ff[SQRT_REM_W-3:0], rad_ff[SQRT_RAD_W-1 -: 2]};
   assign trial  = {{(SQRT_REM_W-SQRT_ROOT_W-2){1'b0}}, root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == '0);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CntW'(SQRT_ROOT_W - 1);
         end else if (busy_ff) begin
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff <= {rad_ff[SQRT_RAD_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_ff  <= rem_sh - trial;
            root_ff <= {root_ff[SQRT_ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh;
            root_ff <= {root_ff[SQRT_ROOT_W-2:0], 1'b0};
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

FILE: rtl/caf_div.sv
module caf_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic signed [caf_pkg::DIV_W-1:0] dividend,
   input  logic [caf_pkg::DIVISOR_W-1:0]   divisor,
   output logic                            done,
   output logic signed [caf_pkg::DIV_W-1:0] quotient
);
   import caf_pkg::*;

   localparam int CntW = $clog2(DIV_W);

   logic [DIVISOR_W:0]   rem_ff;
   logic [DIV_W-1:0]     quo_ff;
   logic [DIVISOR_W-1:0] div_ff;
   logic                 neg_ff;
   logic [CntW-1:0]      cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [DIVISOR_W:0]   rem_sh;

   assign rem_sh = {rem_ff[DIVISOR_W-1:0], quo_ff[DIV_W-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == '0);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CntW'(DIV_W - 1);
         end else if (busy_ff) begin
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend[DIV_W-1] ? -dividend : dividend;
         div_ff <= divisor;
         neg_ff <= dividend[DIV_W-1];
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, div_ff}) begin
            rem_ff <= rem_sh - {1'b0, div_ff};
            quo_ff <= {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[DIV_W-2:0], 1'b0};
         end
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);
endmodule

FILE: rtl/cartesian_admittance_filter.sv
// Cartesian admittance filter: one axis sample per beat in, one result beat out, Q16.16.
// Commanded position and velocity per axis live in a small memory whose valid bits
// clear on reset, so no clearing pass is needed. One item is worked at a time: a
// pass-through or bad axis/order item goes straight to the result stage; a compliant
// axis runs a 26-step bit-serial square root, then a 64-step shift-subtract divider
// unless the divisor is zero. A new beat is taken as soon as the result register is
// loaded, even while that result still waits. Write configuration only while idle.
module cartesian_admittance_filter #(
   parameter int NUM_AXES = caf_pkg::NUM_AXES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   caf_stream_if.sink                        req_ch,
   caf_stream_if.source                      rsp_ch,
   input  logic                              csr_we,
   input  logic [caf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [caf_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import caf_pkg::*;

   localparam int AddrW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

   typedef enum logic [12:0] {
      S_IDLE   = 13'b0000000000001,
      S_LOAD   = 13'b0000000000010,
      S_SQRT   = 13'b0000000000100,
      S_DAMP   = 13'b0000000001000,
      S_PREP   = 13'b0000000010000,
      S_NUM    = 13'b0000000100000,
      S_DIV    = 13'b0000001000000,
      S_FIRST  = 13'b0000010000000,
      S_MULV   = 13'b0000100000000,
      S_ADDV   = 13'b0001000000000,
      S_MULX   = 13'b0010000000000,
      S_ADDX   = 13'b0100000000000,
      S_FINISH = 13'b1000000000000
   } state_type;

   function automatic logic [COEF_W-1:0] pick(input logic [CSR_DATA_W-1:0] lo,
                                              input logic [CSR_DATA_W-1:0] hi,
                                              input logic [AXIS_W-1:0] ax);
      case (ax)
         3'd0: return lo[15:0];
         3'd1: return lo[31:16];
         3'd2: return lo[47:32];
         3'd3: return hi[15:0];
         3'd4: return hi[31:16];
         default: return hi[47:32];
      endcase
   endfunction

   logic [CSR_DATA_W-1:0] stiff_lo_ff, stiff_hi_ff, mass_lo_ff, mass_hi_ff;
   logic [CSR_DATA_W-1:0] ratio_lo_ff, ratio_hi_ff;
   logic [7:0]            mode_ff;
   logic [DT_W-1:0]       dt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stiff_lo_ff <= '0;
         stiff_hi_ff <= '0;
         mass_lo_ff  <= '0;
         mass_hi_ff  <= '0;
         ratio_lo_ff <= '0;
         ratio_hi_ff <= '0;
         mode_ff     <= '0;
         dt_ff       <= DT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_STIFF_LO: stiff_lo_ff <= csr_wdata;
            CSR_STIFF_HI: stiff_hi_ff <= csr_wdata;
            CSR_MASS_LO:  mass_lo_ff  <= csr_wdata;
            CSR_MASS_HI:  mass_hi_ff  <= csr_wdata;
            CSR_RATIO_LO: ratio_lo_ff <= csr_wdata;
            CSR_RATIO_HI: ratio_hi_ff <= csr_wdata;
            CSR_MODE:     mode_ff     <= csr_wdata[7:0];
            CSR_DT:       dt_ff       <= csr_wdata[DT_W-1:0];
            default: ;
         endcase
      end
   end

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff;

   req_payload_type req_ff;
   logic [COEF_W-1:0] k_ff, m_ff, z_ff;
   order_type         order_ff;
   logic [2*COEF_W-1:0] mk_ff;
   logic signed [DATA_W-1:0] xo_ff, vo_ff;
   logic signed [DATA_W:0]   ex_ff, ev_ff;
   logic [COEF_W+SQRT_ROOT_W-1:0] zs_ff;
   logic [30:0]              d_ff;
   logic signed [49:0]       kex_ff;
   logic signed [64:0]       dev_ff;
   logic signed [DIV_W-1:0]  q_ff;
   logic signed [56:0]       prod_ff;
   logic signed [DATA_W-1:0] x_ff, v_ff, a_ff;
   status_type               status_ff;
   logic                     sat_ff;
   logic                     store_ff;

   logic        req_fire;
   logic        axis_bad;
   logic        item_bad;
   logic [MASK_W-1:0] mask;
   logic        compliant;
   logic [COEF_W-1:0] k_pick, m_pick, z_pick;
   logic        load_out;

   axis_state_type mem_rd, mem_wr;
   logic        sqrt_done;
   logic [SQRT_ROOT_W-1:0] sqrt_root;
   logic        div_start, div_done;
   logic signed [DIV_W-1:0] div_q;
   logic signed [DIV_W-1:0] dividend;
   logic [DIVISOR_W-1:0]    divisor;
   logic signed [DIV_W-1:0] h16, kex64, dev64, num1, num2;
   logic signed [DIV_W-1:0] sum_first, sum_v, sum_x;
   logic [DATA_W:0]         sat_first, sat_v, sat_x;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign axis_bad     = 32'(req_ch.payload.axis) >= 32'(NUM_AXES);
   assign item_bad     = axis_bad || (mode_ff[1:0] == ORDER_BAD);
   assign mask         = mode_ff[7:2];
   assign compliant    = mask[req_ch.payload.axis];
   assign k_pick       = pick(stiff_lo_ff, stiff_hi_ff, req_ch.payload.axis);
   assign m_pick       = pick(mass_lo_ff, mass_hi_ff, req_ch.payload.axis);
   assign z_pick       = pick(ratio_lo_ff, ratio_hi_ff, req_ch.payload.axis);
   assign load_out     = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ch.ready);

   assign h16   = {{28{req_ff.wrench_error[31]}}, req_ff.wrench_error, 4'b0000};
   assign kex64 = {{14{kex_ff[49]}}, kex_ff};
   assign dev64 = {{11{dev_ff[64]}}, dev_ff[64:12]};
   assign num1  = h16 + kex64;
   assign num2  = h16 + dev64 + kex64;

   always_comb begin
      case (order_ff)
         ORDER_SPRING: begin
            dividend = h16;
            divisor  = {16'd0, k_ff};
         end
         ORDER_DAMPER: begin
            dividend = {num1[51:0], 12'd0};
            divisor  = {1'b0, d_ff};
         end
         default: begin
            dividend = {num2[59:0], 4'd0};
            divisor  = {16'd0, m_ff};
         end
      endcase
   end

   assign div_start = (state_ff == S_NUM) && (divisor != '0);

   always_comb begin
      case (order_ff)
         ORDER_SPRING: sum_first = {{32{req_ff.position_ref[31]}}, req_ff.position_ref} + q_ff;
         ORDER_DAMPER: sum_first = {{32{req_ff.velocity_ref[31]}}, req_ff.velocity_ref} + q_ff;
         default:      sum_first = {{32{req_ff.accel_ref[31]}}, req_ff.accel_ref} + q_ff;
      endcase
   end

   assign sum_v     = {{32{vo_ff[31]}}, vo_ff} + {{31{prod_ff[56]}}, prod_ff[56:24]};
   assign sum_x     = {{32{xo_ff[31]}}, xo_ff} + {{31{prod_ff[56]}}, prod_ff[56:24]};
   assign sat_first = sat32(sum_first);
   assign sat_v     = sat32(sum_v);
   assign sat_x     = sat32(sum_x);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = (item_bad || !compliant) ? S_FINISH : S_LOAD;
            end
         end
         S_LOAD: state_in = S_SQRT;
         S_SQRT: begin
            if (sqrt_done) begin
               state_in = S_DAMP;
            end
         end
         S_DAMP: state_in = S_PREP;
         S_PREP: state_in = S_NUM;
         S_NUM:  state_in = (divisor == '0) ? S_FINISH : S_DIV;
         S_DIV: begin
            if (div_done) begin
               state_in = S_FIRST;
            end
         end
         S_FIRST: begin
            case (order_ff)
               ORDER_SPRING: state_in = S_FINISH;
               ORDER_DAMPER: state_in = S_MULX;
               default:      state_in = S_MULV;
            endcase
         end
         S_MULV: state_in = S_ADDV;
         S_ADDV: state_in = S_MULX;
         S_MULX: state_in = S_ADDX;
         S_ADDX: state_in = S_FINISH;
         S_FINISH: begin
            if (load_out) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = load_out || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               req_ff   <= req_ch.payload;
               k_ff     <= k_pick;
               m_ff     <= m_pick;
               z_ff     <= z_pick;
               order_ff <= order_type'(mode_ff[1:0]);
               mk_ff    <= m_pick * k_pick;
               sat_ff   <= 1'b0;
               store_ff <= !item_bad;
               if (item_bad) begin
                  x_ff      <= '0;
                  v_ff      <= '0;
                  a_ff      <= '0;
                  status_ff <= STATUS_BAD_ORDER;
               end else begin
                  x_ff      <= req_ch.payload.position_ref;
                  v_ff      <= req_ch.payload.velocity_ref;
                  a_ff      <= req_ch.payload.accel_ref;
                  status_ff <= STATUS_OK;
               end
            end
         end
         S_LOAD: begin
            xo_ff <= mem_rd.position;
            vo_ff <= mem_rd.velocity;
            ex_ff <= {req_ff.position_ref[31], req_ff.position_ref}
                     - {mem_rd.position[31], mem_rd.position};
            ev_ff <= {req_ff.velocity_ref[31], req_ff.velocity_ref}
                     - {mem_rd.velocity[31], mem_rd.velocity};
         end
         S_SQRT: begin
            if (sqrt_done) begin
               zs_ff <= z_ff * sqrt_root;
            end
         end
         S_DAMP: d_ff <= zs_ff[41:11];
         S_PREP: begin
            kex_ff <= $signed({1'b0, k_ff}) * ex_ff;
            dev_ff <= $signed({1'b0, d_ff}) * ev_ff;
         end
         S_NUM: begin
            if (divisor == '0) begin
               x_ff      <= '0;
               v_ff      <= '0;
               a_ff      <= '0;
               status_ff <= STATUS_ZERO_DIV;
               store_ff  <= 1'b0;
            end
         end
         S_DIV: begin
            if (div_done) begin
               q_ff <= div_q;
            end
         end
         S_FIRST: begin
            sat_ff <= sat_ff | sat_first[DATA_W];
            case (order_ff)
               ORDER_SPRING: x_ff <= sat_first[DATA_W-1:0];
               ORDER_DAMPER: v_ff <= sat_first[DATA_W-1:0];
               default:      a_ff <= sat_first[DATA_W-1:0];
            endcase
         end
         S_MULV: prod_ff <= a_ff * $signed({1'b0, dt_ff});
         S_ADDV: begin
            v_ff   <= sat_v[DATA_W-1:0];
            sat_ff <= sat_ff | sat_v[DATA_W];
         end
         S_MULX: prod_ff <= v_ff * $signed({1'b0, dt_ff});
         S_ADDX: begin
            x_ff   <= sat_x[DATA_W-1:0];
            sat_ff <= sat_ff | sat_x[DATA_W];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_ff.axis_out     <= req_ff.axis;
         rsp_ff.position_cmd <= x_ff;
         rsp_ff.velocity_cmd <= v_ff;
         rsp_ff.accel_cmd    <= a_ff;
         rsp_ff.status       <= (status_ff == STATUS_OK && sat_ff) ? STATUS_SAT : status_ff;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_ff;

   assign mem_wr.position = x_ff;
   assign mem_wr.velocity = v_ff;

   caf_state_mem #(
      .Depth (NUM_AXES),
      .AddrW (AddrW)
   ) u_state (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_fire && !item_bad && compliant),
      .rd_addr (req_ch.payload.axis[AddrW-1:0]),
      .rd_data (mem_rd),
      .wr_en   (load_out && store_ff),
      .wr_addr (req_ff.axis[AddrW-1:0]),
      .wr_data (mem_wr)
   );

   caf_isqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == S_LOAD),
      .radicand ({mk_ff, 20'd0}),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   caf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (div_q)
   );
endmodule
